// ===== src/plar_pkg.sv =====
// plar_pkg: types, constants and command codes of the path arc length resampler
// used by every module of the block, no dependencies
`default_nettype none

package plar_pkg;

  localparam int MAX_STEPS  = 64;
  localparam int NW         = 7;
  localparam int MUL_ITERS  = 34;
  localparam int SQRT_ITERS = 34;
  localparam int DIV_ITERS  = 48;
  localparam logic [30:0] STEP_RESET = 31'd6554;
  localparam logic signed [15:0] QUAT_ONE = 16'sd16384;
  localparam logic [2:0] IDX_POS_LAST  = 3'd2;
  localparam logic [2:0] IDX_COMP_LAST = 3'd6;
  localparam logic [2:0] IDX_QUAT_LAST = 3'd3;

  typedef enum logic [1:0] {
    AR_MUL,
    AR_SQRT,
    AR_DIV
  } arith_op_t;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_FIRST,
    DP_SCLR,
    DP_SQ_POS,
    DP_SACC,
    DP_SQRT_S,
    DP_DIST,
    DP_DIRECT,
    DP_NDIV,
    DP_NSET,
    DP_LERP_MUL,
    DP_LERP_DIV,
    DP_LSET,
    DP_SQ_Q,
    DP_QZERO,
    DP_SQRT_Q,
    DP_RSET,
    DP_QDIV,
    DP_QSET,
    DP_EMIT
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_FIRST,
    S_DSQ,
    S_DSQ_W,
    S_DSQRT,
    S_DSQRT_W,
    S_DECIDE,
    S_DIRECT,
    S_NDIV,
    S_NDIV_W,
    S_LMUL,
    S_LMUL_W,
    S_LDIV_W,
    S_QCLR,
    S_QSQ,
    S_QSQ_W,
    S_QCHK,
    S_QSQRT_W,
    S_QDIV,
    S_QDIV_W,
    S_EMIT
  } state_t;

  typedef struct packed {
    dp_op_t     op;
    logic [2:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic unit_done;
    logic in_start;
    logic active;
    logic acc_ge_step;
    logic one_pose;
    logic k_last;
    logic s_zero;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== src/plar_if.sv =====
// plar_if: valid/ready channels for input poses and output waypoints
// standalone, no package needed
`default_nettype none

interface plar_pose_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic               path_start;
  modport source(output valid, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z,
                 path_start, input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z,
               path_start, output ready);
endinterface

interface plar_wp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_pos_x;
  logic signed [31:0] out_pos_y;
  logic signed [31:0] out_pos_z;
  logic signed [15:0] out_quat_w;
  logic signed [15:0] out_quat_x;
  logic signed [15:0] out_quat_y;
  logic signed [15:0] out_quat_z;
  logic               last_of_run;
  logic               steps_clipped;
  modport source(output valid, out_pos_x, out_pos_y, out_pos_z, out_quat_w, out_quat_x,
                 out_quat_y, out_quat_z, last_of_run, steps_clipped, input ready);
  modport sink(input valid, out_pos_x, out_pos_y, out_pos_z, out_quat_w, out_quat_x,
               out_quat_y, out_quat_z, last_of_run, steps_clipped, output ready);
endinterface

`default_nettype wire

// ===== src/plar_arith.sv =====
// plar_arith: shared bit-serial unit for multiply, square root and divide
// depends on plar_pkg
`default_nettype none

module plar_arith (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire plar_pkg::arith_op_t op,
  input  wire logic [67:0]       a,
  input  wire logic [33:0]       b,
  output logic                   done,
  output logic [67:0]            res
);
  import plar_pkg::*;

  logic        busy;
  logic [5:0]  cnt;
  arith_op_t   opr;
  logic [67:0] x;
  logic [33:0] y;
  logic [67:0] acc;
  logic [37:0] rem;
  logic [37:0] remt;
  logic [37:0] trial;
  logic [37:0] remd;

  assign res = acc;

  always_comb begin
    remt  = {rem[35:0], x[67:66]};
    trial = {2'b00, acc[33:0], 2'b01};
    remd  = {rem[36:0], x[47]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        case (op)
          AR_MUL:  cnt <= 6'(MUL_ITERS);
          AR_SQRT: cnt <= 6'(SQRT_ITERS);
          default: cnt <= 6'(DIV_ITERS);
        endcase
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      opr <= op;
      x   <= a;
      y   <= b;
      acc <= '0;
      rem <= '0;
    end else if (busy) begin
      case (opr)
        AR_MUL: begin
          if (y[0]) acc <= acc + x;
          x <= {x[66:0], 1'b0};
          y <= {1'b0, y[33:1]};
        end
        AR_SQRT: begin
          if (remt >= trial) begin
            rem <= remt - trial;
            acc <= {acc[66:0], 1'b1};
          end else begin
            rem <= remt;
            acc <= {acc[66:0], 1'b0};
          end
          x <= {x[65:0], 2'b00};
        end
        default: begin
          if (remd >= {4'b0000, y}) begin
            rem <= remd - {4'b0000, y};
            acc <= {acc[66:0], 1'b1};
          end else begin
            rem <= remd;
            acc <= {acc[66:0], 1'b0};
          end
          x <= {x[66:0], 1'b0};
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/plar_datapath.sv =====
// plar_datapath: pose, waypoint and accumulator registers, output register
// depends on plar_pkg, plar_if and plar_arith
`default_nettype none

module plar_datapath (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_wr_en,
  input  wire logic [30:0]      cfg_wr_data,
  input  wire plar_pkg::dp_cmd_t cmd,
  output plar_pkg::dp_stat_t    stat,
  plar_pose_if.sink             pose,
  plar_wp_if.source             waypoint
);
  import plar_pkg::*;

  logic [30:0]        step;
  logic signed [31:0] p [3];
  logic signed [15:0] q [4];
  logic               start_f;
  logic signed [31:0] lwp [3];
  logic signed [15:0] lwq [4];
  logic signed [31:0] prev [3];
  logic [31:0]        acc;
  logic [1:0]         pse;
  logic               active;
  logic [33:0]        d;
  logic [NW-1:0]      n;
  logic [NW-1:0]      k;
  logic               clip;
  logic [67:0]        s;
  logic [33:0]        r;
  logic signed [31:0] np [3];
  logic signed [15:0] nq [4];
  logic signed [15:0] oq [4];
  logic               ovalid;

  logic               ar_start;
  arith_op_t          ar_op;
  logic [67:0]        ar_a;
  logic [33:0]        ar_b;
  logic               ar_done;
  logic [67:0]        ar_res;

  logic [30:0]        step_eff;
  logic signed [32:0] pdiff;
  logic [32:0]        pmag;
  logic [1:0]         qi;
  logic signed [33:0] la;
  logic signed [33:0] lb;
  logic signed [33:0] ld;
  logic [33:0]        lmag;
  logic signed [33:0] lval;
  logic [16:0]        qmag;
  logic [34:0]        asum;
  logic               out_free;

  plar_arith u_arith (
    .clk   (clk),
    .rst   (rst),
    .start (ar_start),
    .op    (ar_op),
    .a     (ar_a),
    .b     (ar_b),
    .done  (ar_done),
    .res   (ar_res)
  );

  assign step_eff = (step == 31'd0) ? 31'd1 : step;
  assign out_free = !ovalid || waypoint.ready;
  assign qi       = cmd.idx[1:0] + 2'd1;

  always_comb begin
    pdiff = {p[cmd.idx[1:0]][31], p[cmd.idx[1:0]]} - {prev[cmd.idx[1:0]][31],
            prev[cmd.idx[1:0]]};
    pmag  = pdiff[32] ? 33'(-pdiff) : 33'(pdiff);
    if (cmd.idx <= IDX_POS_LAST) begin
      la = 34'(lwp[cmd.idx[1:0]]);
      lb = 34'(p[cmd.idx[1:0]]);
    end else begin
      la = 34'(lwq[qi]);
      lb = 34'(q[qi]);
    end
    ld   = lb - la;
    lmag = ld[33] ? 34'(-ld) : 34'(ld);
    lval = ld[33] ? la - $signed(ar_res[33:0]) : la + $signed(ar_res[33:0]);
    qmag = nq[cmd.idx[1:0]][15] ? 17'(-{nq[cmd.idx[1:0]][15], nq[cmd.idx[1:0]]})
                                : {1'b0, nq[cmd.idx[1:0]]};
    asum = {3'b000, acc} + {1'b0, ar_res[33:0]};
  end

  always_comb begin
    ar_start = 1'b0;
    ar_op    = AR_MUL;
    ar_a     = '0;
    ar_b     = '0;
    case (cmd.op)
      DP_SQ_POS: begin
        ar_start = 1'b1;
        ar_a     = 68'(pmag);
        ar_b     = 34'(pmag);
      end
      DP_SQRT_S: begin
        ar_start = 1'b1;
        ar_op    = AR_SQRT;
        ar_a     = s;
      end
      DP_NDIV: begin
        ar_start = 1'b1;
        ar_op    = AR_DIV;
        ar_a     = 68'(d);
        ar_b     = 34'(step_eff);
      end
      DP_LERP_MUL: begin
        ar_start = 1'b1;
        ar_a     = 68'(lmag);
        ar_b     = 34'(k);
      end
      DP_LERP_DIV: begin
        ar_start = 1'b1;
        ar_op    = AR_DIV;
        ar_a     = ar_res + 68'(n >> 1);
        ar_b     = 34'(n);
      end
      DP_SQ_Q: begin
        ar_start = 1'b1;
        ar_a     = 68'(qmag);
        ar_b     = 34'(qmag);
      end
      DP_SQRT_Q: begin
        ar_start = 1'b1;
        ar_op    = AR_SQRT;
        ar_a     = {s[39:0], 28'd0};
      end
      DP_QDIV: begin
        ar_start = 1'b1;
        ar_op    = AR_DIV;
        ar_a     = {23'd0, qmag, 28'd0} + 68'(r >> 1);
        ar_b     = r;
      end
      default: begin
        ar_start = 1'b0;
      end
    endcase
  end

  always_comb begin
    stat.unit_done   = ar_done;
    stat.in_start    = start_f;
    stat.active      = active;
    stat.acc_ge_step = acc >= {1'b0, step_eff};
    stat.one_pose    = (pse == 2'd1);
    stat.k_last      = (k == n);
    stat.s_zero      = (s == '0);
    stat.out_free    = out_free;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      step   <= STEP_RESET;
      acc    <= '0;
      pse    <= '0;
      active <= 1'b0;
      ovalid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        lwp[i]  <= '0;
        prev[i] <= '0;
      end
      for (int i = 0; i < 4; i++) lwq[i] <= '0;
    end else begin
      if (cfg_wr_en) step <= cfg_wr_data;
      if (cmd.op inside {DP_FIRST, DP_DIRECT, DP_EMIT}) ovalid <= 1'b1;
      else if (ovalid && waypoint.ready) ovalid <= 1'b0;
      case (cmd.op)
        DP_FIRST: begin
          for (int i = 0; i < 3; i++) begin
            lwp[i]  <= p[i];
            prev[i] <= p[i];
          end
          for (int i = 0; i < 4; i++) lwq[i] <= q[i];
          acc    <= '0;
          pse    <= '0;
          active <= 1'b1;
        end
        DP_DIST: begin
          acc <= (asum[34:32] != 3'd0) ? '1 : asum[31:0];
          if (pse != 2'd3) pse <= pse + 2'd1;
          for (int i = 0; i < 3; i++) prev[i] <= p[i];
        end
        DP_DIRECT: begin
          for (int i = 0; i < 3; i++) lwp[i] <= p[i];
          for (int i = 0; i < 4; i++) lwq[i] <= q[i];
          acc    <= '0;
          pse    <= '0;
        end
        DP_EMIT: begin
          if (k == n) begin
            for (int i = 0; i < 3; i++) lwp[i] <= np[i];
            for (int i = 0; i < 4; i++) lwq[i] <= oq[i];
            acc <= '0;
            pse <= '0;
          end
        end
        default: begin
          acc <= acc;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        p[0]    <= pose.pos_x;
        p[1]    <= pose.pos_y;
        p[2]    <= pose.pos_z;
        q[0]    <= pose.quat_w;
        q[1]    <= pose.quat_x;
        q[2]    <= pose.quat_y;
        q[3]    <= pose.quat_z;
        start_f <= pose.path_start;
      end
      DP_FIRST, DP_DIRECT: begin
        waypoint.out_pos_x     <= p[0];
        waypoint.out_pos_y     <= p[1];
        waypoint.out_pos_z     <= p[2];
        waypoint.out_quat_w    <= q[0];
        waypoint.out_quat_x    <= q[1];
        waypoint.out_quat_y    <= q[2];
        waypoint.out_quat_z    <= q[3];
        waypoint.last_of_run   <= 1'b1;
        waypoint.steps_clipped <= 1'b0;
      end
      DP_SCLR:   s <= '0;
      DP_SACC:   s <= s + ar_res;
      DP_DIST:   d <= ar_res[33:0];
      DP_NSET: begin
        k <= NW'(1);
        if (ar_res > 68'(MAX_STEPS)) begin
          n    <= NW'(MAX_STEPS);
          clip <= 1'b1;
        end else if (ar_res == '0) begin
          n    <= NW'(1);
          clip <= 1'b0;
        end else begin
          n    <= ar_res[NW-1:0];
          clip <= 1'b0;
        end
      end
      DP_LSET: begin
        if (cmd.idx <= IDX_POS_LAST) np[cmd.idx[1:0]] <= lval[31:0];
        else nq[qi] <= lval[15:0];
      end
      DP_QZERO: begin
        oq[0] <= QUAT_ONE;
        oq[1] <= '0;
        oq[2] <= '0;
        oq[3] <= '0;
      end
      DP_RSET: r <= ar_res[33:0];
      DP_QSET: begin
        oq[cmd.idx[1:0]] <= nq[cmd.idx[1:0]][15] ? -$signed(ar_res[15:0])
                                                  : $signed(ar_res[15:0]);
      end
      DP_EMIT: begin
        waypoint.out_pos_x     <= np[0];
        waypoint.out_pos_y     <= np[1];
        waypoint.out_pos_z     <= np[2];
        waypoint.out_quat_w    <= oq[0];
        waypoint.out_quat_x    <= oq[1];
        waypoint.out_quat_y    <= oq[2];
        waypoint.out_quat_z    <= oq[3];
        waypoint.last_of_run   <= (k == n);
        waypoint.steps_clipped <= clip;
        k <= k + NW'(1);
      end
      default: begin
        s <= s;
      end
    endcase
  end

  assign waypoint.valid = ovalid;

endmodule

`default_nettype wire

// ===== src/plar_ctrl.sv =====
// plar_ctrl: sequencer of the resampler, issues datapath commands
// depends on plar_pkg
`default_nettype none

module plar_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire plar_pkg::dp_stat_t stat,
  output plar_pkg::dp_cmd_t      cmd
);
  import plar_pkg::*;

  state_t     state;
  state_t     state_next;
  logic [2:0] idx;
  logic [2:0] idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    idx_next   = idx;
    case (state)
      S_IDLE:    if (in_valid) state_next = S_CHECK;
      S_CHECK: begin
        idx_next = '0;
        if (stat.in_start) state_next = S_FIRST;
        else if (!stat.active) state_next = S_IDLE;
        else state_next = S_DSQ;
      end
      S_FIRST:   if (stat.out_free) state_next = S_IDLE;
      S_DSQ:     state_next = S_DSQ_W;
      S_DSQ_W: begin
        if (stat.unit_done) begin
          if (idx == IDX_POS_LAST) state_next = S_DSQRT;
          else begin
            idx_next   = idx + 3'd1;
            state_next = S_DSQ;
          end
        end
      end
      S_DSQRT:   state_next = S_DSQRT_W;
      S_DSQRT_W: if (stat.unit_done) state_next = S_DECIDE;
      S_DECIDE: begin
        if (!stat.acc_ge_step) state_next = S_IDLE;
        else if (stat.one_pose) state_next = S_NDIV;
        else state_next = S_DIRECT;
      end
      S_DIRECT:  if (stat.out_free) state_next = S_IDLE;
      S_NDIV:    state_next = S_NDIV_W;
      S_NDIV_W: begin
        if (stat.unit_done) begin
          idx_next   = '0;
          state_next = S_LMUL;
        end
      end
      S_LMUL:    state_next = S_LMUL_W;
      S_LMUL_W:  if (stat.unit_done) state_next = S_LDIV_W;
      S_LDIV_W: begin
        if (stat.unit_done) begin
          if (idx == IDX_COMP_LAST) state_next = S_QCLR;
          else begin
            idx_next   = idx + 3'd1;
            state_next = S_LMUL;
          end
        end
      end
      S_QCLR: begin
        idx_next   = '0;
        state_next = S_QSQ;
      end
      S_QSQ:     state_next = S_QSQ_W;
      S_QSQ_W: begin
        if (stat.unit_done) begin
          if (idx == IDX_QUAT_LAST) state_next = S_QCHK;
          else begin
            idx_next   = idx + 3'd1;
            state_next = S_QSQ;
          end
        end
      end
      S_QCHK:    state_next = stat.s_zero ? S_EMIT : S_QSQRT_W;
      S_QSQRT_W: begin
        if (stat.unit_done) begin
          idx_next   = '0;
          state_next = S_QDIV;
        end
      end
      S_QDIV:    state_next = S_QDIV_W;
      S_QDIV_W: begin
        if (stat.unit_done) begin
          if (idx == IDX_QUAT_LAST) state_next = S_EMIT;
          else begin
            idx_next   = idx + 3'd1;
            state_next = S_QDIV;
          end
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          idx_next   = '0;
          state_next = stat.k_last ? S_IDLE : S_LMUL;
        end
      end
      default:   state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    cmd.op   = DP_NOP;
    cmd.idx  = idx;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = DP_LOAD;
      end
      S_CHECK:   if (!stat.in_start && stat.active) cmd.op = DP_SCLR;
      S_FIRST:   if (stat.out_free) cmd.op = DP_FIRST;
      S_DSQ:     cmd.op = DP_SQ_POS;
      S_DSQ_W:   if (stat.unit_done) cmd.op = DP_SACC;
      S_DSQRT:   cmd.op = DP_SQRT_S;
      S_DSQRT_W: if (stat.unit_done) cmd.op = DP_DIST;
      S_DIRECT:  if (stat.out_free) cmd.op = DP_DIRECT;
      S_NDIV:    cmd.op = DP_NDIV;
      S_NDIV_W:  if (stat.unit_done) cmd.op = DP_NSET;
      S_LMUL:    cmd.op = DP_LERP_MUL;
      S_LMUL_W:  if (stat.unit_done) cmd.op = DP_LERP_DIV;
      S_LDIV_W:  if (stat.unit_done) cmd.op = DP_LSET;
      S_QCLR:    cmd.op = DP_SCLR;
      S_QSQ:     cmd.op = DP_SQ_Q;
      S_QSQ_W:   if (stat.unit_done) cmd.op = DP_SACC;
      S_QCHK:    cmd.op = stat.s_zero ? DP_QZERO : DP_SQRT_Q;
      S_QSQRT_W: if (stat.unit_done) cmd.op = DP_RSET;
      S_QDIV:    cmd.op = DP_QDIV;
      S_QDIV_W:  if (stat.unit_done) cmd.op = DP_QSET;
      S_EMIT:    if (stat.out_free) cmd.op = DP_EMIT;
      default:   cmd.op = DP_NOP;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/path_arc_length_resampler.sv =====
// path_arc_length_resampler: top level, joins sequencer and datapath
// depends on plar_pkg, plar_if, plar_ctrl, plar_datapath
//
// Poses enter on the pose channel (valid/ready), waypoints leave on the
// waypoint channel; step_length is written by cfg_wr_en/cfg_wr_data, and
// the user must do so only while idle; the block does not enforce this.
// One pose is processed at a time, all arithmetic going through one shared
// bit-serial unit (34 iterations per multiply or root, 48 per divide).
// A path start pose is loaded in S_IDLE, passes S_CHECK and has its waypoint
// written to the output register from S_FIRST.
// For any other pose the distance takes three squares and a root; a direct
// emit writes the pose to the output register from S_DIRECT.
// An interpolated run first divides for the step count, then per waypoint
// does seven lerp multiply/divide pairs, four squares and, unless the lerped
// quaternion is zero, a root and four divides of the normalisation.
// The next pose is taken as soon as the last waypoint of the run sits in the
// output register, while that register still waits to be taken.
// If the receiver stalls, the sequencer holds before writing the output
// register and resumes once it frees.
// Reset clears the path state, the accumulator and step_length to 6554.
`default_nettype none

module path_arc_length_resampler (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  cfg_wr_en,
  input  wire logic [30:0] cfg_wr_data,
  plar_pose_if.sink  pose,
  plar_wp_if.source  waypoint
);
  import plar_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  plar_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pose.valid),
    .in_ready (pose.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  plar_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .stat        (stat),
    .pose        (pose),
    .waypoint    (waypoint)
  );

endmodule

`default_nettype wire
